[sv/hthd_pkg.sv]
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder package
// Shared types and constants for the frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hthd_pkg;

    // Widths of the raw sensor values and of the assembled data field.
    localparam int unsigned RAW_W  = 20;
    localparam int unsigned DATA_W = 2 * RAW_W;

    // One completed frame, handed from the frame assembler to the scaler.
    typedef struct packed {
        logic [7:0]       status;
        logic [RAW_W-1:0] raw_h;
        logic [RAW_W-1:0] raw_t;
        logic             ok;
    } frame_rec_t;

endpackage : hthd_pkg

`default_nettype wire

[sv/hthd_frame.sv]
// ----------------------------------------------------------------------------
// Frame assembler
// Tracks the byte position in a sensor frame, runs the CRC-8 (poly 0x31,
// init 0xFF), collects the five data bytes and registers one record per
// completed frame.
// ----------------------------------------------------------------------------
`default_nettype none

module hthd_frame
    import hthd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_take,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_start,
    input  wire logic       crc_enable,
    input  wire logic       rec_take,
    output logic            rec_valid,
    output frame_rec_t      rec
);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Position of the next expected byte within the frame.
    typedef enum logic [2:0] {
        POS_IDLE = 3'd0,
        POS_D1   = 3'd1,
        POS_D2   = 3'd2,
        POS_D3   = 3'd3,
        POS_D4   = 3'd4,
        POS_D5   = 3'd5,
        POS_CRC  = 3'd6
    } pos_t;

    pos_t              pos_reg;
    pos_t              pos_next;
    logic [7:0]        crc_reg;
    logic [7:0]        crc_next;
    logic [7:0]        status_reg;
    logic [7:0]        status_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              done;
    logic              done_ok;
    logic              rec_valid_reg;
    frame_rec_t        rec_reg;

    // Bytewise CRC-8 update, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Next frame state for an accepted byte.
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        data_next   = data_reg;
        done        = 1'b0;
        done_ok     = 1'b1;
        if (byte_take)
        begin
            if (frame_start)
            begin
                status_next = rx_byte;
                crc_next    = crc8_update(CRC_INIT, rx_byte);
                data_next   = '0;
                pos_next    = POS_D1;
            end
            else
            begin
                case (pos_reg)
                    POS_D1, POS_D2, POS_D3, POS_D4:
                    begin
                        data_next = {data_reg[DATA_W-9:0], rx_byte};
                        crc_next  = crc8_update(crc_reg, rx_byte);
                        pos_next  = pos_t'(pos_reg + 3'd1);
                    end
                    POS_D5:
                    begin
                        data_next = {data_reg[DATA_W-9:0], rx_byte};
                        crc_next  = crc8_update(crc_reg, rx_byte);
                        if (crc_enable)
                        begin
                            pos_next = POS_CRC;
                        end
                        else
                        begin
                            pos_next = POS_IDLE;
                            done     = 1'b1;
                        end
                    end
                    POS_CRC:
                    begin
                        pos_next = POS_IDLE;
                        done     = 1'b1;
                        done_ok  = (rx_byte == crc_reg);
                    end
                    default:
                    begin
                        pos_next = POS_IDLE;
                    end
                endcase
            end
        end
    end

    // Frame state and the registered record of a completed frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            crc_reg       <= CRC_INIT;
            status_reg    <= '0;
            data_reg      <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            if (done)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (rec_take)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rec_reg.status <= status_reg;
            rec_reg.raw_h  <= data_next[DATA_W-1:RAW_W];
            rec_reg.raw_t  <= data_next[RAW_W-1:0];
            rec_reg.ok     <= done_ok;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule : hthd_frame

`default_nettype wire

[sv/hthd_scale.sv]
// ----------------------------------------------------------------------------
// Value scaler and output register
// Converts the raw values of a frame record to tenths of a percent and
// tenths of a degree and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hthd_scale
    import hthd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rec_valid,
    input  wire frame_rec_t   rec,
    output logic              rec_take,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [7:0]        status_byte,
    output logic [9:0]        humidity_tenth_pct,
    output logic signed [11:0] temperature_tenth_deg,
    output logic              crc_ok
);

    localparam int unsigned HUM_PROD_W  = RAW_W + 10;
    localparam int unsigned TEMP_PROD_W = RAW_W + 11;
    localparam logic [HUM_PROD_W-1:0]  HUM_SCALE   = HUM_PROD_W'(1000);
    localparam logic [TEMP_PROD_W-1:0] TEMP_SCALE  = TEMP_PROD_W'(2000);
    localparam logic [11:0]            TEMP_OFFSET = 12'd500;

    logic [HUM_PROD_W-1:0]  hum_prod;
    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [9:0]             hum_val;
    logic [11:0]            temp_val;
    logic                   out_valid_reg;
    logic [7:0]             status_reg;
    logic [9:0]             hum_reg;
    logic [11:0]            temp_reg;
    logic                   ok_reg;

    // Fixed-point scaling: multiply by the full-scale span, keep the top bits.
    always_comb
    begin
        hum_prod  = HUM_PROD_W'(rec.raw_h) * HUM_SCALE;
        temp_prod = TEMP_PROD_W'(rec.raw_t) * TEMP_SCALE;
        if (rec.ok)
        begin
            hum_val  = hum_prod[HUM_PROD_W-1:RAW_W];
            temp_val = {1'b0, temp_prod[TEMP_PROD_W-1:RAW_W]} - TEMP_OFFSET;
        end
        else
        begin
            hum_val  = '0;
            temp_val = '0;
        end
    end

    // The output register takes a new beat when empty or being drained.
    assign rec_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rec_take)
        begin
            out_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take && rec_valid)
        begin
            status_reg <= rec.status;
            hum_reg    <= hum_val;
            temp_reg   <= temp_val;
            ok_reg     <= rec.ok;
        end
    end

    assign out_valid             = out_valid_reg;
    assign status_byte           = status_reg;
    assign humidity_tenth_pct    = hum_reg;
    assign temperature_tenth_deg = $signed(temp_reg);
    assign crc_ok                = ok_reg;

endmodule : hthd_scale

`default_nettype wire

[sv/humidity_temp_frame_decoder.sv]
// ----------------------------------------------------------------------------
// Humidity/temperature frame decoder
// Top level: byte input channel, configuration register, result channel.
// ----------------------------------------------------------------------------
// The block takes one sensor byte per beat and can accept a byte in every
// cycle unless stalled. A frame is a status byte (marked by frame_start),
// five data bytes and, with crc_enable set, a CRC-8 byte (poly 0x31, init
// 0xFF). One result beat leaves per completed frame, held in the frame
// assembler's record register, then in the output register after the
// scaling multipliers. Both registers let the input keep flowing while a
// result waits; the input stalls only when both hold a frame and out_stall
// is high. A frame with a bad CRC reports the status byte with zero values.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder
    import hthd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         status_byte,
    output logic [9:0]         humidity_tenth_pct,
    output logic signed [11:0] temperature_tenth_deg,
    output logic               crc_ok
);

    logic       crc_enable_reg;
    logic       byte_take;
    logic       rec_valid;
    logic       rec_take;
    frame_rec_t rec;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            crc_enable_reg <= cfg_data;
        end
    end

    // Stall input only while a finished record cannot move on.
    assign in_stall  = rec_valid && !rec_take;
    assign byte_take = in_valid && !in_stall;

    hthd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .crc_enable  (crc_enable_reg),
        .rec_take    (rec_take),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    hthd_scale u_scale (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .rec_valid             (rec_valid),
        .rec                   (rec),
        .rec_take              (rec_take),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .status_byte           (status_byte),
        .humidity_tenth_pct    (humidity_tenth_pct),
        .temperature_tenth_deg (temperature_tenth_deg),
        .crc_ok                (crc_ok)
    );

    // A failed CRC check must zero both measurements.
    a_crc_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !crc_ok |-> humidity_tenth_pct == 10'd0 && temperature_tenth_deg == 12'sd0)
        else $error("CRC failure beat carries nonzero values");

    // Humidity scaling stays below full scale.
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity_tenth_pct <= 10'd999)
        else $error("humidity out of range");

    // Temperature offset stays within the sensor span.
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_tenth_deg >= -12'sd500 && temperature_tenth_deg <= 12'sd1499)
        else $error("temperature out of range");

    // Input is held back only when the record register is full and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> rec_valid && out_valid && out_stall)
        else $error("input stalled without a blocked record");

endmodule : humidity_temp_frame_decoder

`default_nettype wire
